/* hw/rtl/pssd_pkg.sv */
// Shared types, widths and multiplier helpers for the periodic segment distance unit.
package pssd_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int EXTRA_BITS  = 12;
  localparam int BOX_W       = 31;
  localparam int DIST_W      = 31;

  // shifted coordinates stay below 2^33 in magnitude
  localparam int PT_W     = COORD_WIDTH + 2;
  localparam int NUM_W    = COORD_WIDTH + 3;
  localparam int DIFF_W   = PT_W + 1;
  localparam int HALF_W   = (DIFF_W + 2) / 2;
  localparam int MAG_W    = 2 * HALF_W;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int SQ_W     = 2 * PT_W + 1;
  localparam int RAD_W    = SQ_W + 2 * EXTRA_BITS + (SQ_W % 2);
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int QNUM_W   = SQ_W + EXTRA_BITS;
  localparam int QHI_W    = QNUM_W - DIST_W;
  localparam int PSD_LAT  = ROOT_W + DIST_W + 7;

  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [BOX_W-1:0]  BOX_RESET = 31'd6553600;

  typedef enum logic [1:0] {
    REG_BOX_WIDTH,
    REG_BOX_HEIGHT,
    REG_WRAP_X,
    REG_WRAP_Y
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_start_x;
    logic signed [COORD_WIDTH-1:0] first_start_y;
    logic signed [COORD_WIDTH-1:0] first_end_x;
    logic signed [COORD_WIDTH-1:0] first_end_y;
    logic signed [COORD_WIDTH-1:0] second_start_x;
    logic signed [COORD_WIDTH-1:0] second_start_y;
    logic signed [COORD_WIDTH-1:0] second_end_x;
    logic signed [COORD_WIDTH-1:0] second_end_y;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              crossing;
  } result_t;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
  } pt_t;

  // magnitude partial products of one signed multiply
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] ll;
    logic [MAG_W-1:0] lh;
    logic [MAG_W-1:0] hl;
    logic [MAG_W-1:0] hh;
  } mpart_t;

  function automatic mpart_t mul_parts(input logic signed [DIFF_W-1:0] a,
                                       input logic signed [DIFF_W-1:0] b);
    logic signed [MAG_W-1:0] ae;
    logic signed [MAG_W-1:0] be;
    logic [MAG_W-1:0]        ma;
    logic [MAG_W-1:0]        mb;
    mpart_t                  r;
    ae = MAG_W'(a);
    be = MAG_W'(b);
    ma = ae[MAG_W-1] ? $unsigned(-ae) : $unsigned(ae);
    mb = be[MAG_W-1] ? $unsigned(-be) : $unsigned(be);
    r.neg = a[DIFF_W-1] ^ b[DIFF_W-1];
    r.ll = MAG_W'(ma[HALF_W-1:0]) * MAG_W'(mb[HALF_W-1:0]);
    r.lh = MAG_W'(ma[HALF_W-1:0]) * MAG_W'(mb[MAG_W-1:HALF_W]);
    r.hl = MAG_W'(ma[MAG_W-1:HALF_W]) * MAG_W'(mb[HALF_W-1:0]);
    r.hh = MAG_W'(ma[MAG_W-1:HALF_W]) * MAG_W'(mb[MAG_W-1:HALF_W]);
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] mul_join(input mpart_t p);
    logic [PROD_W-1:0] s;
    s = PROD_W'(p.ll) + (PROD_W'(p.lh) << HALF_W) + (PROD_W'(p.hl) << HALF_W)
        + (PROD_W'(p.hh) << MAG_W);
    return p.neg ? -$signed(s) : $signed(s);
  endfunction

endpackage

/* hw/rtl/pssd_point_seg.sv */
// Pipelined point-to-segment distance: products, case select, root and divide stages.
module pssd_point_seg (
  input  logic                          clk,
  input  logic                          adv,
  input  pssd_pkg::pt_t                 p,
  input  pssd_pkg::pt_t                 a,
  input  pssd_pkg::pt_t                 b,
  output logic [pssd_pkg::DIST_W-1:0]   distance
);

  typedef struct packed {
    logic [pssd_pkg::RAD_W-1:0]  rad;
    logic [pssd_pkg::REM_W-1:0]  rem;
    logic [pssd_pkg::ROOT_W-1:0] root;
    logic                        interior;
    logic [pssd_pkg::SQ_W-1:0]   cmag;
  } sq_t;

  typedef struct packed {
    logic [pssd_pkg::ROOT_W-1:0] den;
    logic [pssd_pkg::ROOT_W-1:0] r;
    logic [pssd_pkg::DIST_W-1:0] q;
    logic                        sat;
    logic                        interior;
    logic [pssd_pkg::DIST_W-1:0] vres;
    logic [pssd_pkg::DIST_W-1:0] lo;
  } dv_t;

  // stage 1: difference vectors
  logic signed [pssd_pkg::DIFF_W-1:0] abx, aby, apx, apy, bpx, bpy;

  always_ff @(posedge clk) begin
    if (adv) begin
      abx <= pssd_pkg::DIFF_W'(b.x) - pssd_pkg::DIFF_W'(a.x);
      aby <= pssd_pkg::DIFF_W'(b.y) - pssd_pkg::DIFF_W'(a.y);
      apx <= pssd_pkg::DIFF_W'(p.x) - pssd_pkg::DIFF_W'(a.x);
      apy <= pssd_pkg::DIFF_W'(p.y) - pssd_pkg::DIFF_W'(a.y);
      bpx <= pssd_pkg::DIFF_W'(p.x) - pssd_pkg::DIFF_W'(b.x);
      bpy <= pssd_pkg::DIFF_W'(p.y) - pssd_pkg::DIFF_W'(b.y);
    end
  end

  // stage 2: partial products
  // 0,1: |ab|^2  2,3: dot  4,5: cross  6,7: |ap|^2  8,9: |bp|^2
  pssd_pkg::mpart_t mp [10];

  always_ff @(posedge clk) begin
    if (adv) begin
      mp[0] <= pssd_pkg::mul_parts(abx, abx);
      mp[1] <= pssd_pkg::mul_parts(aby, aby);
      mp[2] <= pssd_pkg::mul_parts(apx, abx);
      mp[3] <= pssd_pkg::mul_parts(apy, aby);
      mp[4] <= pssd_pkg::mul_parts(abx, apy);
      mp[5] <= pssd_pkg::mul_parts(aby, apx);
      mp[6] <= pssd_pkg::mul_parts(apx, apx);
      mp[7] <= pssd_pkg::mul_parts(apy, apy);
      mp[8] <= pssd_pkg::mul_parts(bpx, bpx);
      mp[9] <= pssd_pkg::mul_parts(bpy, bpy);
    end
  end

  // stage 3: full products
  logic signed [pssd_pkg::PROD_W-1:0] pr [10];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 10; i++) begin
        pr[i] <= pssd_pkg::mul_join(mp[i]);
      end
    end
  end

  // stage 4: sums
  logic signed [pssd_pkg::SUM_W-1:0] ab2, dot, crs, la2, lb2;

  always_ff @(posedge clk) begin
    if (adv) begin
      ab2 <= pssd_pkg::SUM_W'(pr[0]) + pssd_pkg::SUM_W'(pr[1]);
      dot <= pssd_pkg::SUM_W'(pr[2]) + pssd_pkg::SUM_W'(pr[3]);
      crs <= pssd_pkg::SUM_W'(pr[4]) - pssd_pkg::SUM_W'(pr[5]);
      la2 <= pssd_pkg::SUM_W'(pr[6]) + pssd_pkg::SUM_W'(pr[7]);
      lb2 <= pssd_pkg::SUM_W'(pr[8]) + pssd_pkg::SUM_W'(pr[9]);
    end
  end

  // stage 5: pick the case and the radicand
  logic                              seg_zero, dot_le, dot_ge, interior, use_end;
  logic signed [pssd_pkg::SUM_W-1:0] crs_abs;
  sq_t                               s5;

  always_comb begin
    seg_zero = (ab2 == '0);
    dot_le   = dot[pssd_pkg::SUM_W-1] || (dot == '0);
    dot_ge   = (dot >= ab2);
    interior = !seg_zero && !dot_le && !dot_ge;
    use_end  = !seg_zero && !dot_le && dot_ge;
    crs_abs  = crs[pssd_pkg::SUM_W-1] ? -crs : crs;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (interior) begin
        s5.rad <= pssd_pkg::RAD_W'({ab2[pssd_pkg::SQ_W-1:0],
                                    {(2 * pssd_pkg::EXTRA_BITS){1'b0}}});
      end else if (use_end) begin
        s5.rad <= pssd_pkg::RAD_W'(lb2[pssd_pkg::SQ_W-1:0]);
      end else begin
        s5.rad <= pssd_pkg::RAD_W'(la2[pssd_pkg::SQ_W-1:0]);
      end
      s5.rem      <= '0;
      s5.root     <= '0;
      s5.interior <= interior;
      s5.cmag     <= crs_abs[pssd_pkg::SQ_W-1:0];
    end
  end

  // square root, one result bit per stage
  sq_t sq [pssd_pkg::ROOT_W];

  genvar k;
  for (k = 0; k < pssd_pkg::ROOT_W; k++) begin : g_sq
    sq_t                         prv;
    sq_t                         nxt;
    logic [pssd_pkg::REM_W+1:0]  t;
    logic [pssd_pkg::REM_W+1:0]  trial;

    if (k == 0) begin : g_first
      assign prv = s5;
    end else begin : g_next
      assign prv = sq[k-1];
    end

    always_comb begin
      nxt   = prv;
      t     = {prv.rem, prv.rad[pssd_pkg::RAD_W-1-2*k -: 2]};
      trial = (pssd_pkg::REM_W+2)'({prv.root, 2'b01});
      if (t >= trial) begin
        nxt.rem  = pssd_pkg::REM_W'(t - trial);
        nxt.root = {prv.root[pssd_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        nxt.rem  = t[pssd_pkg::REM_W-1:0];
        nxt.root = {prv.root[pssd_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq[k] <= nxt;
      end
    end
  end

  // divide setup: quotient of 2^31 or more saturates
  logic [pssd_pkg::QNUM_W-1:0] qnum;
  logic [pssd_pkg::QHI_W-1:0]  qhi;
  sq_t                         sqo;
  dv_t                         d0;

  assign sqo  = sq[pssd_pkg::ROOT_W-1];
  assign qnum = {sqo.cmag, {pssd_pkg::EXTRA_BITS{1'b0}}};
  assign qhi  = qnum[pssd_pkg::QNUM_W-1 -: pssd_pkg::QHI_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      d0.den      <= sqo.root;
      d0.r        <= qhi[pssd_pkg::ROOT_W-1:0];
      d0.q        <= '0;
      d0.sat      <= (qhi >= pssd_pkg::QHI_W'(sqo.root));
      d0.interior <= sqo.interior;
      d0.vres     <= (|sqo.root[pssd_pkg::ROOT_W-1:pssd_pkg::DIST_W]) ? pssd_pkg::DIST_MAX
                                                    : sqo.root[pssd_pkg::DIST_W-1:0];
      d0.lo       <= qnum[pssd_pkg::DIST_W-1:0];
    end
  end

  // restoring divide, one quotient bit per stage
  dv_t dv [pssd_pkg::DIST_W];

  genvar j;
  for (j = 0; j < pssd_pkg::DIST_W; j++) begin : g_dv
    dv_t                          prv;
    dv_t                          nxt;
    logic [pssd_pkg::ROOT_W:0]    t;

    if (j == 0) begin : g_first
      assign prv = d0;
    end else begin : g_next
      assign prv = dv[j-1];
    end

    always_comb begin
      nxt = prv;
      t   = {prv.r, prv.lo[pssd_pkg::DIST_W-1-j]};
      if (t >= {1'b0, prv.den}) begin
        nxt.r = pssd_pkg::ROOT_W'(t - {1'b0, prv.den});
        nxt.q[pssd_pkg::DIST_W-1-j] = 1'b1;
      end else begin
        nxt.r = t[pssd_pkg::ROOT_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[j] <= nxt;
      end
    end
  end

  dv_t dvo;
  assign dvo = dv[pssd_pkg::DIST_W-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!dvo.interior) begin
        distance <= dvo.vres;
      end else if (dvo.sat) begin
        distance <= pssd_pkg::DIST_MAX;
      end else begin
        distance <= dvo.q;
      end
    end
  end

endmodule

/* hw/rtl/periodic_segment_segment_distance_unit.sv */
// Top level: minimum-image shift, orientation test and four point-to-segment distances.
//
// Takes one segment pair per clock cycle unless the result channel stalls. The pipeline
// depth is set by three bit-serial units laid out as pipeline stages: the
// minimum-image remainder (35 stages), the square root of the segment length or point
// distance (47 stages) and the interior-distance divide (31 stages). Stalling the result
// channel holds the whole pipeline; while the result register is empty or being taken,
// items keep entering. Box and wrap registers are read directly by the pipeline and
// should only be written while it is empty.
module periodic_segment_segment_distance_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  pssd_pkg::item_t        item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output pssd_pkg::result_t      result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  typedef struct packed {
    pssd_pkg::item_t                it;
    logic [pssd_pkg::NUM_W-1:0]     numx;
    logic [pssd_pkg::NUM_W-1:0]     numy;
    logic                           negx;
    logic                           negy;
    logic [pssd_pkg::BOX_W:0]       remx;
    logic [pssd_pkg::BOX_W:0]       remy;
  } dq_t;

  // configuration
  logic [pssd_pkg::BOX_W-1:0] box_width, box_height;
  logic                       wrap_x, wrap_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width  <= pssd_pkg::BOX_RESET;
      box_height <= pssd_pkg::BOX_RESET;
      wrap_x     <= 1'b1;
      wrap_y     <= 1'b1;
    end else if (cfg_valid) begin
      case (pssd_pkg::cfg_reg_t'(cfg_index))
        pssd_pkg::REG_BOX_WIDTH:  box_width  <= cfg_data[pssd_pkg::BOX_W-1:0];
        pssd_pkg::REG_BOX_HEIGHT: box_height <= cfg_data[pssd_pkg::BOX_W-1:0];
        pssd_pkg::REG_WRAP_X:     wrap_x     <= cfg_data[0];
        pssd_pkg::REG_WRAP_Y:     wrap_y     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless a finished result is held
  logic adv;
  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  // stage 0: input register
  logic            v0;
  pssd_pkg::item_t it0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it0 <= item;
    end
  end

  // stage 1: twice the midpoint separation per axis
  logic                             v1;
  pssd_pkg::item_t                  it1;
  logic signed [pssd_pkg::PT_W-1:0] sx, sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1 <= it0;
      sx  <= (pssd_pkg::PT_W'(it0.first_start_x) + pssd_pkg::PT_W'(it0.first_end_x))
           - (pssd_pkg::PT_W'(it0.second_start_x) + pssd_pkg::PT_W'(it0.second_end_x));
      sy  <= (pssd_pkg::PT_W'(it0.first_start_y) + pssd_pkg::PT_W'(it0.first_end_y))
           - (pssd_pkg::PT_W'(it0.second_start_y) + pssd_pkg::PT_W'(it0.second_end_y));
    end
  end

  // stage 2: dividend |s| + box, for rounding half away from zero
  logic                             v2;
  dq_t                              s2;
  logic signed [pssd_pkg::PT_W-1:0] magx, magy;

  assign magx = sx[pssd_pkg::PT_W-1] ? -sx : sx;
  assign magy = sy[pssd_pkg::PT_W-1] ? -sy : sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2.it   <= it1;
      s2.numx <= pssd_pkg::NUM_W'($unsigned(magx)) + pssd_pkg::NUM_W'(box_width);
      s2.numy <= pssd_pkg::NUM_W'($unsigned(magy)) + pssd_pkg::NUM_W'(box_height);
      s2.negx <= sx[pssd_pkg::PT_W-1];
      s2.negy <= sy[pssd_pkg::PT_W-1];
      s2.remx <= '0;
      s2.remy <= '0;
    end
  end

  // remainder of dividend over twice the box, one bit per stage
  dq_t                        dq [pssd_pkg::NUM_W];
  logic [pssd_pkg::NUM_W-1:0] vq;
  logic [pssd_pkg::BOX_W:0]   divx, divy;

  assign divx = {box_width, 1'b0};
  assign divy = {box_height, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (adv) begin
      vq <= {vq[pssd_pkg::NUM_W-2:0], v2};
    end
  end

  genvar k;
  for (k = 0; k < pssd_pkg::NUM_W; k++) begin : g_div
    dq_t                        prv;
    dq_t                        nxt;
    logic [pssd_pkg::BOX_W+1:0] tx, ty;

    if (k == 0) begin : g_first
      assign prv = s2;
    end else begin : g_next
      assign prv = dq[k-1];
    end

    always_comb begin
      nxt = prv;
      tx  = {prv.remx, prv.numx[pssd_pkg::NUM_W-1-k]};
      ty  = {prv.remy, prv.numy[pssd_pkg::NUM_W-1-k]};
      if (tx >= {1'b0, divx}) begin
        nxt.remx = (pssd_pkg::BOX_W+1)'(tx - {1'b0, divx});
      end else begin
        nxt.remx = tx[pssd_pkg::BOX_W:0];
      end
      if (ty >= {1'b0, divy}) begin
        nxt.remy = (pssd_pkg::BOX_W+1)'(ty - {1'b0, divy});
      end else begin
        nxt.remy = ty[pssd_pkg::BOX_W:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dq[k] <= nxt;
      end
    end
  end

  // shift = box * n = (dividend - remainder) / 2
  dq_t                        dqo;
  logic                       enx, eny;
  logic [pssd_pkg::NUM_W-1:0] difx, dify;
  logic                       vx1;
  pssd_pkg::item_t            itx1;
  logic                       negx1, negy1;
  logic [pssd_pkg::NUM_W-2:0] shx, shy;

  assign dqo  = dq[pssd_pkg::NUM_W-1];
  assign enx  = wrap_x && (box_width != '0);
  assign eny  = wrap_y && (box_height != '0);
  assign difx = dqo.numx - pssd_pkg::NUM_W'(dqo.remx);
  assign dify = dqo.numy - pssd_pkg::NUM_W'(dqo.remy);

  always_ff @(posedge clk) begin
    if (rst) begin
      vx1 <= 1'b0;
    end else if (adv) begin
      vx1 <= vq[pssd_pkg::NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      itx1  <= dqo.it;
      negx1 <= dqo.negx;
      negy1 <= dqo.negy;
      shx   <= enx ? difx[pssd_pkg::NUM_W-1:1] : '0;
      shy   <= eny ? dify[pssd_pkg::NUM_W-1:1] : '0;
    end
  end

  // moved endpoints
  logic          vt;
  pssd_pkg::pt_t ta, tb, tc, td;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else if (adv) begin
      vt <= vx1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ta.x <= negx1 ? pssd_pkg::PT_W'(itx1.first_start_x) + shx
                    : pssd_pkg::PT_W'(itx1.first_start_x) - shx;
      tb.x <= negx1 ? pssd_pkg::PT_W'(itx1.first_end_x) + shx
                    : pssd_pkg::PT_W'(itx1.first_end_x) - shx;
      ta.y <= negy1 ? pssd_pkg::PT_W'(itx1.first_start_y) + shy
                    : pssd_pkg::PT_W'(itx1.first_start_y) - shy;
      tb.y <= negy1 ? pssd_pkg::PT_W'(itx1.first_end_y) + shy
                    : pssd_pkg::PT_W'(itx1.first_end_y) - shy;
      tc.x <= pssd_pkg::PT_W'(itx1.second_start_x);
      tc.y <= pssd_pkg::PT_W'(itx1.second_start_y);
      td.x <= pssd_pkg::PT_W'(itx1.second_end_x);
      td.y <= pssd_pkg::PT_W'(itx1.second_end_y);
    end
  end

  // four endpoint-to-segment distances
  logic [pssd_pkg::DIST_W-1:0] dist0, dist1, dist2, dist3;

  pssd_point_seg u_ps0 (.clk(clk), .adv(adv), .p(ta), .a(tc), .b(td), .distance(dist0));
  pssd_point_seg u_ps1 (.clk(clk), .adv(adv), .p(tb), .a(tc), .b(td), .distance(dist1));
  pssd_point_seg u_ps2 (.clk(clk), .adv(adv), .p(tc), .a(ta), .b(tb), .distance(dist2));
  pssd_point_seg u_ps3 (.clk(clk), .adv(adv), .p(td), .a(ta), .b(tb), .distance(dist3));

  // orientation: products pair up as (2i, 2i+1) for abc, abd, cda, cdb
  logic signed [pssd_pkg::DIFF_W-1:0] od [12];
  pssd_pkg::mpart_t                   om [8];
  logic signed [pssd_pkg::PROD_W-1:0] op [8];
  logic [3:0]                         ogt, olt;
  logic                               crossing;

  always_ff @(posedge clk) begin
    if (adv) begin
      od[0]  <= pssd_pkg::DIFF_W'(tb.y) - pssd_pkg::DIFF_W'(ta.y);
      od[1]  <= pssd_pkg::DIFF_W'(tc.x) - pssd_pkg::DIFF_W'(tb.x);
      od[2]  <= pssd_pkg::DIFF_W'(tb.x) - pssd_pkg::DIFF_W'(ta.x);
      od[3]  <= pssd_pkg::DIFF_W'(tc.y) - pssd_pkg::DIFF_W'(tb.y);
      od[4]  <= pssd_pkg::DIFF_W'(td.x) - pssd_pkg::DIFF_W'(tb.x);
      od[5]  <= pssd_pkg::DIFF_W'(td.y) - pssd_pkg::DIFF_W'(tb.y);
      od[6]  <= pssd_pkg::DIFF_W'(td.y) - pssd_pkg::DIFF_W'(tc.y);
      od[7]  <= pssd_pkg::DIFF_W'(ta.x) - pssd_pkg::DIFF_W'(td.x);
      od[8]  <= pssd_pkg::DIFF_W'(td.x) - pssd_pkg::DIFF_W'(tc.x);
      od[9]  <= pssd_pkg::DIFF_W'(ta.y) - pssd_pkg::DIFF_W'(td.y);
      od[10] <= pssd_pkg::DIFF_W'(tb.x) - pssd_pkg::DIFF_W'(td.x);
      od[11] <= pssd_pkg::DIFF_W'(tb.y) - pssd_pkg::DIFF_W'(td.y);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      om[0] <= pssd_pkg::mul_parts(od[0], od[1]);
      om[1] <= pssd_pkg::mul_parts(od[2], od[3]);
      om[2] <= pssd_pkg::mul_parts(od[0], od[4]);
      om[3] <= pssd_pkg::mul_parts(od[2], od[5]);
      om[4] <= pssd_pkg::mul_parts(od[6], od[7]);
      om[5] <= pssd_pkg::mul_parts(od[8], od[9]);
      om[6] <= pssd_pkg::mul_parts(od[6], od[10]);
      om[7] <= pssd_pkg::mul_parts(od[8], od[11]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) begin
        op[i] <= pssd_pkg::mul_join(om[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ogt[i] = (op[2*i] > op[2*i+1]);
      olt[i] = (op[2*i] < op[2*i+1]);
    end
    crossing = ({ogt[0], olt[0]} != {ogt[1], olt[1]}) &&
               ({ogt[2], olt[2]} != {ogt[3], olt[3]});
  end

  // valid and crossing flag ride alongside the distance units
  logic [pssd_pkg::PSD_LAT-1:0] vd;
  logic [pssd_pkg::PSD_LAT-4:0] xd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (adv) begin
      vd <= {vd[pssd_pkg::PSD_LAT-2:0], vt};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xd <= {xd[pssd_pkg::PSD_LAT-5:0], crossing};
    end
  end

  // minimum of the four, then output register
  logic                        vm, xm;
  logic [pssd_pkg::DIST_W-1:0] m01, m23;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      vm           <= vd[pssd_pkg::PSD_LAT-1];
      result_valid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m01             <= (dist1 < dist0) ? dist1 : dist0;
      m23             <= (dist3 < dist2) ? dist3 : dist2;
      xm              <= xd[pssd_pkg::PSD_LAT-4];
      result.distance <= xm ? '0 : ((m23 < m01) ? m23 : m01);
      result.crossing <= xm;
    end
  end

endmodule

/* tb/periodic_segment_segment_distance_unit_tb.sv */
// Self-checking testbench for the periodic segment-to-segment distance unit.
module periodic_segment_segment_distance_unit_tb;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    pssd_pkg::item_t   pair;
    logic              known;
    pssd_pkg::result_t res;
  } pair_row_t;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 150;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  pssd_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall;
  pssd_pkg::result_t result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [31:0]       cfg_data;

  // shadow of the box and wrap registers
  logic [pssd_pkg::BOX_W-1:0] box_w_q;
  logic [pssd_pkg::BOX_W-1:0] box_h_q;
  logic                       wrap_x_q;
  logic                       wrap_y_q;

  pssd_pkg::result_t dist_expected[$];
  int          errors = 0;
  int          pairs_sent;
  int          results_seen = 0;
  int          crossings_seen = 0;
  int          cycle_cnt = 0;
  int          stall_hold;
  logic        gaps_on;

  periodic_segment_segment_distance_unit u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [pssd_pkg::DIST_W-1:0] clip(logic [127:0] v);
    return (v > 128'h7FFF_FFFF) ? pssd_pkg::DIST_MAX : v[pssd_pkg::DIST_W-1:0];
  endfunction

  function automatic logic [pssd_pkg::DIST_W-1:0] vlen(wide_t x, wide_t y);
    return clip(isqrt(x * x + y * y));
  endfunction

  function automatic logic [pssd_pkg::DIST_W-1:0] point_to_seg(wide_t px, wide_t py,
                                                               wide_t ax, wide_t ay,
                                                               wide_t bx, wide_t by);
    wide_t abx, aby, apx, apy, ab2, dot, cr;
    logic [63:0] den;
    abx = bx - ax; aby = by - ay; apx = px - ax; apy = py - ay;
    ab2 = abx * abx + aby * aby;
    if (ab2 == 0) return vlen(apx, apy);
    dot = apx * abx + apy * aby;
    if (dot <= 0) return vlen(apx, apy);
    if (dot >= ab2) return vlen(px - bx, py - by);
    cr = abx * apy - aby * apx;
    if (cr < 0) cr = -cr;
    den = isqrt($unsigned(ab2 <<< (2 * pssd_pkg::EXTRA_BITS)));
    return clip($unsigned(cr <<< pssd_pkg::EXTRA_BITS) / {64'd0, den});
  endfunction

  function automatic int orient(wide_t px, wide_t py, wide_t qx, wide_t qy,
                                wide_t rx, wide_t ry);
    wide_t c;
    c = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    return (c == 0) ? 0 : ((c > 0) ? 1 : 2);
  endfunction

  function automatic wide_t image_shift(wide_t dsum, logic [pssd_pkg::BOX_W-1:0] box);
    wide_t bw, mag, n;
    bw = box;
    if (bw == 0) return 0;
    mag = (dsum < 0) ? -dsum : dsum;
    n = (mag + bw) / (2 * bw);
    return (dsum < 0) ? -(n * bw) : n * bw;
  endfunction

  function automatic pssd_pkg::result_t predict_distance(pssd_pkg::item_t p);
    wide_t ax, ay, bx, by, cx, cy, dx, dy, s;
    logic [pssd_pkg::DIST_W-1:0] d, t;
    logic cr;
    pssd_pkg::result_t r;
    ax = p.first_start_x;  ay = p.first_start_y;
    bx = p.first_end_x;    by = p.first_end_y;
    cx = p.second_start_x; cy = p.second_start_y;
    dx = p.second_end_x;   dy = p.second_end_y;
    if (wrap_x_q) begin
      s = image_shift((ax + bx) - (cx + dx), box_w_q);
      ax -= s; bx -= s;
    end
    if (wrap_y_q) begin
      s = image_shift((ay + by) - (cy + dy), box_h_q);
      ay -= s; by -= s;
    end
    d = point_to_seg(ax, ay, cx, cy, dx, dy);
    t = point_to_seg(bx, by, cx, cy, dx, dy); if (t < d) d = t;
    t = point_to_seg(cx, cy, ax, ay, bx, by); if (t < d) d = t;
    t = point_to_seg(dx, dy, ax, ay, bx, by); if (t < d) d = t;
    cr = (orient(ax, ay, bx, by, cx, cy) != orient(ax, ay, bx, by, dx, dy)) &&
         (orient(cx, cy, dx, dy, ax, ay) != orient(cx, cy, dx, dy, bx, by));
    r.distance = cr ? '0 : d;
    r.crossing = cr;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (!gaps_on || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] q16(int v);
    return 32'(v) << 16;
  endfunction

  function automatic logic [31:0] rand_coord(int mode, int span);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2 * span)) - span);
      default: return q16($urandom_range(0, 8) - 4) | ($urandom_range(0, 3) << 14);
    endcase
  endfunction

  function automatic pssd_pkg::item_t random_pair();
    pssd_pkg::item_t p;
    int mode, span, kind;
    kind = $urandom_range(0, 19);
    mode = (kind < 2) ? 0 : ((kind < 12) ? 1 : 2);
    span = 1 << $urandom_range(8, 30);
    p.first_start_x  = rand_coord(mode, span);
    p.first_start_y  = rand_coord(mode, span);
    p.first_end_x    = rand_coord(mode, span);
    p.first_end_y    = rand_coord(mode, span);
    p.second_start_x = rand_coord(mode, span);
    p.second_start_y = rand_coord(mode, span);
    p.second_end_x   = rand_coord(mode, span);
    p.second_end_y   = rand_coord(mode, span);
    // degenerate and touching shapes
    case ($urandom_range(0, 9))
      0: begin p.first_end_x = p.first_start_x; p.first_end_y = p.first_start_y; end
      1: begin p.second_end_x = p.second_start_x; p.second_end_y = p.second_start_y; end
      2: begin p.second_start_x = p.first_end_x; p.second_start_y = p.first_end_y; end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pair(pssd_pkg::item_t p, logic known, pssd_pkg::result_t res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= p;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    dist_expected.push_back(known ? res : predict_distance(p));
    pairs_sent++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (dist_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(pssd_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      pssd_pkg::REG_BOX_WIDTH:  box_w_q  = val[pssd_pkg::BOX_W-1:0];
      pssd_pkg::REG_BOX_HEIGHT: box_h_q  = val[pssd_pkg::BOX_W-1:0];
      pssd_pkg::REG_WRAP_X:     wrap_x_q = val[0];
      pssd_pkg::REG_WRAP_Y:     wrap_y_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] w, logic [31:0] h, logic wx, logic wy);
    write_reg(pssd_pkg::REG_BOX_WIDTH, w);
    write_reg(pssd_pkg::REG_BOX_HEIGHT, h);
    write_reg(pssd_pkg::REG_WRAP_X, {31'(0), wx});
    write_reg(pssd_pkg::REG_WRAP_Y, {31'(0), wy});
  endtask

  task automatic random_run(int n);
    pssd_pkg::result_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      send_pair(random_pair(), 1'b0, none);
    end
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_hold   <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case ($urandom_range(0, 19)) inside
        [0:11]:  begin result_stall <= 1'b0; stall_hold <= $urandom_range(0, 30); end
        [12:18]: begin result_stall <= 1'b1; stall_hold <= $urandom_range(0, 2); end
        default: begin result_stall <= 1'b1; stall_hold <= $urandom_range(20, 60); end
      endcase
    end
  end

  always @(posedge clk) begin
    pssd_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (result.crossing) crossings_seen++;
      if (dist_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction distance=%h crossing=%b",
                 $time, result.distance, result.crossing);
      end else begin
        want = dist_expected.pop_front();
        if (result.distance !== want.distance) begin
          errors++;
          $display("%0t: distance expected %h actual %h", $time, want.distance,
                   result.distance);
        end
        if (result.crossing !== want.crossing) begin
          errors++;
          $display("%0t: crossing expected %b actual %b", $time, want.crossing,
                   result.crossing);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout with %0d transactions outstanding", dist_expected.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    pair_row_t         rows[$];
    pair_row_t         row;
    pssd_pkg::result_t none;
    none = '0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= pssd_pkg::REG_BOX_WIDTH;
    cfg_data <= '0;
    pairs_sent = 0;
    gaps_on = 1'b1;
    box_w_q = pssd_pkg::BOX_RESET; box_h_q = pssd_pkg::BOX_RESET;
    wrap_x_q = 1'b1; wrap_y_q = 1'b1;

    // all-zero pair: coincident points, no crossing
    row.pair = '0; row.known = 1'b1; row.res = '{distance: '0, crossing: 1'b0};
    rows.push_back(row);
    // an X through the origin crosses
    row.pair = '{q16(-1), q16(-1), q16(1), q16(1), q16(-1), q16(1), q16(1), q16(-1)};
    row.res = '{distance: '0, crossing: 1'b1};
    rows.push_back(row);
    row.known = 1'b0; row.res = none;
    // parallel, separated by 2.0 (interior projection)
    row.pair = '{q16(0), q16(0), q16(4), q16(0), q16(1), q16(2), q16(3), q16(2)};
    rows.push_back(row);
    // projection before start and past end
    row.pair = '{q16(-5), q16(1), q16(-3), q16(1), q16(0), q16(0), q16(4), q16(0)};
    rows.push_back(row);
    row.pair = '{q16(7), q16(1), q16(9), q16(3), q16(0), q16(0), q16(4), q16(0)};
    rows.push_back(row);
    // zero-length segments on either side
    row.pair = '{q16(2), q16(3), q16(2), q16(3), q16(0), q16(0), q16(4), q16(0)};
    rows.push_back(row);
    row.pair = '{q16(0), q16(0), q16(4), q16(0), q16(1), q16(-2), q16(1), q16(-2)};
    rows.push_back(row);
    // collinear overlap and touching end points
    row.pair = '{q16(0), q16(0), q16(4), q16(0), q16(2), q16(0), q16(6), q16(0)};
    rows.push_back(row);
    row.pair = '{q16(0), q16(0), q16(2), q16(2), q16(2), q16(2), q16(4), q16(0)};
    rows.push_back(row);
    // pair lying across the box edge, wrapped on both axes
    row.pair = '{q16(-49), q16(-49), q16(-48), q16(-47), q16(49), q16(49), q16(48), q16(47)};
    rows.push_back(row);
    // extremes of the coordinate range
    row.pair = {8{32'h7FFF_FFFF}};
    rows.push_back(row);
    row.pair = {8{32'h8000_0000}};
    rows.push_back(row);
    row.pair = {{4{32'h8000_0000}}, {4{32'h7FFF_FFFF}}};
    rows.push_back(row);
    row.pair = {32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
    rows.push_back(row);
    row.pair = {32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF,
                32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555};
    rows.push_back(row);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_pair(rows[i].pair, rows[i].known, rows[i].res);
    random_run(150);
    // hold off until the pipeline is empty, then continue
    drain();
    random_run(150);
    drain();

    set_config(32'h7FFF_FFFF, 32'd1, 1'b1, 1'b1);
    foreach (rows[i]) if (!rows[i].known) send_pair(rows[i].pair, 1'b0, none);
    random_run(200);
    drain();

    set_config(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1);
    random_run(200);
    drain();

    set_config(32'd1, 32'h8000_0000 | 32'h7FFF_FFFF, 1'b1, 1'b0);
    random_run(200);
    drain();

    set_config(32'd6553600, 32'd65536, 1'b0, 1'b0);
    random_run(150);
    drain();

    set_config($urandom_range(1, 32'h00FF_FFFF), $urandom_range(1, 32'h00FF_FFFF),
               1'b1, 1'b1);
    gaps_on = 1'b0;
    random_run(200);
    drain();

    $display("%0d segment pairs over six box/wrap settings, %0d results, %0d crossings",
             pairs_sent, results_seen, crossings_seen);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pssd_pkg.sv
hw/rtl/pssd_point_seg.sv
hw/rtl/periodic_segment_segment_distance_unit.sv
tb/periodic_segment_segment_distance_unit_tb.sv
